// ===== src/wsr_pkg.sv =====
// shared types and constants of the waveform scope rasteriser
`default_nettype none
package wsr_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned WIDTH_W    = 10;
    localparam int unsigned HEIGHT_W   = 8;
    localparam int unsigned CENTRE_W   = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;

    // signed row before the clamp: quotient plus centre, two spare bits
    localparam int unsigned ROW_W      = HEIGHT_W + 2;

    // divider operands: 17-bit dividend covers the full-scale constant
    localparam int unsigned DIVIDEND_W = 17;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DIVIDEND_W-1:0] FULL_SCALE = DIVIDEND_W'(65536);
    localparam logic [HEIGHT_W-1:0]   MIN_HEIGHT = HEIGHT_W'(3);
    localparam logic [WIDTH_W-1:0]    RST_WIDTH  = WIDTH_W'(128);
    localparam logic [HEIGHT_W-1:0]   RST_HEIGHT = HEIGHT_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_QUOT_GO,
        S_QUOT_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== src/wsr_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module wsr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsr_pkg::t_div_req i_req,
    output wsr_pkg::t_div_rsp      o_rsp
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [wsr_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [wsr_pkg::DIVISOR_W-1:0]  r_rem, n_rem;
    logic [wsr_pkg::DIVIDEND_W-1:0] r_q, n_q;
    logic [wsr_pkg::DIVISOR_W-1:0]  r_dvs, n_dvs;

    logic [wsr_pkg::DIVISOR_W:0]    shifted;
    logic [wsr_pkg::DIVISOR_W+1:0]  diff;
    logic                           fits;

    always_comb begin
        shifted = {r_rem, r_q[wsr_pkg::DIVIDEND_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        fits    = ~diff[wsr_pkg::DIVISOR_W+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so its low bits suffice
            n_rem = fits ? diff[wsr_pkg::DIVISOR_W-1:0] : shifted[wsr_pkg::DIVISOR_W-1:0];
            n_q   = {r_q[wsr_pkg::DIVIDEND_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == wsr_pkg::DIV_CNT_W'(wsr_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule
`default_nettype wire

// ===== src/waveform_scope_rasterizer.sv =====
// top level: one display column per stereo sample pair, with span to the previous column
// one sample pair in work at a time; the next is accepted once the previous one is loaded
//   into the output register, after two 17-step passes through the
//   shared bit-serial divider (full scale by height, then sample by that ratio)
// a finished result waits in the output register while the next pair is taken
// reset (synchronous, active low): column count and previous row cleared,
//   width 128 and height 64, no beat pending on either side
`default_nettype none
module waveform_scope_rasterizer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [wsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wsr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [wsr_pkg::SAMPLE_W-1:0] i_sample_left,
    input  wire logic signed [wsr_pkg::SAMPLE_W-1:0] i_sample_right,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_frame_first,
    output logic [wsr_pkg::WIDTH_W-1:0]         o_point_column,
    output logic [wsr_pkg::CENTRE_W-1:0]        o_centre_row,
    output logic                                o_span_valid,
    output logic [wsr_pkg::WIDTH_W-1:0]         o_span_column,
    output logic [wsr_pkg::HEIGHT_W-1:0]        o_span_low_row,
    output logic [wsr_pkg::HEIGHT_W-1:0]        o_span_high_row,
    output logic                                o_frame_last
);

    // configuration registers
    logic [wsr_pkg::WIDTH_W-1:0]  r_width;
    logic [wsr_pkg::HEIGHT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsr_pkg::RST_WIDTH;
            r_height <= wsr_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wsr_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[wsr_pkg::WIDTH_W-1:0];
                wsr_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[wsr_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    wsr_pkg::t_state   r_state, n_state;
    wsr_pkg::t_div_req div_req;
    wsr_pkg::t_div_rsp div_rsp;

    logic in_beat, out_beat, out_free;
    assign in_beat  = i_in_valid & o_in_ready;
    assign out_beat = o_out_valid & i_out_ready;
    assign out_free = ~o_out_valid | i_out_ready;

    // per-item working registers
    logic [wsr_pkg::HEIGHT_W-1:0]  r_h;        // height after the lower bound
    logic                          r_neg;      // sign of the averaged sample
    logic [wsr_pkg::SAMPLE_W-1:0]  r_mag;      // magnitude of the average, up to 32768
    logic [wsr_pkg::DIVISOR_W-1:0] r_ratio;
    logic [wsr_pkg::HEIGHT_W-1:0]  r_quot;     // never above 127

    // column state
    logic [wsr_pkg::WIDTH_W-1:0]  r_col;
    logic [wsr_pkg::HEIGHT_W-1:0] r_prev;

    // averaging toward zero: bias negative sums by one before the shift
    logic signed [wsr_pkg::SAMPLE_W:0]   sum;
    logic signed [wsr_pkg::SAMPLE_W:0]   avg;
    logic        [wsr_pkg::SAMPLE_W:0]   avg_mag;

    always_comb begin
        sum     = {i_sample_left[wsr_pkg::SAMPLE_W-1], i_sample_left}
                + {i_sample_right[wsr_pkg::SAMPLE_W-1], i_sample_right};
        avg     = $signed(sum + {{wsr_pkg::SAMPLE_W{1'b0}}, sum[wsr_pkg::SAMPLE_W]}) >>> 1;
        avg_mag = avg[wsr_pkg::SAMPLE_W] ? -avg : avg;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsr_pkg::S_IDLE:       if (in_beat) n_state = wsr_pkg::S_RATIO_GO;
            wsr_pkg::S_RATIO_GO:   n_state = wsr_pkg::S_RATIO_WAIT;
            wsr_pkg::S_RATIO_WAIT: if (div_rsp.done) n_state = wsr_pkg::S_QUOT_GO;
            wsr_pkg::S_QUOT_GO:    n_state = wsr_pkg::S_QUOT_WAIT;
            wsr_pkg::S_QUOT_WAIT:  if (div_rsp.done) n_state = wsr_pkg::S_FINISH;
            wsr_pkg::S_FINISH:     if (out_free) n_state = wsr_pkg::S_IDLE;
            default:               n_state = wsr_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = wsr_pkg::FULL_SCALE;
        div_req.divisor  = {{(wsr_pkg::DIVISOR_W-wsr_pkg::HEIGHT_W){1'b0}}, r_h};
        unique case (r_state)
            wsr_pkg::S_IDLE:     o_in_ready = 1'b1;
            wsr_pkg::S_RATIO_GO: div_req.start = 1'b1;
            wsr_pkg::S_QUOT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, r_mag};
                div_req.divisor  = r_ratio;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wsr_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    wsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_h   <= (r_height < wsr_pkg::MIN_HEIGHT) ? wsr_pkg::MIN_HEIGHT : r_height;
            r_neg <= avg[wsr_pkg::SAMPLE_W];
            r_mag <= avg_mag[wsr_pkg::SAMPLE_W-1:0];
        end
        if (r_state == wsr_pkg::S_RATIO_WAIT && div_rsp.done)
            r_ratio <= div_rsp.quotient[wsr_pkg::DIVISOR_W-1:0];
        if (r_state == wsr_pkg::S_QUOT_WAIT && div_rsp.done)
            r_quot <= div_rsp.quotient[wsr_pkg::HEIGHT_W-1:0];
    end

    // row: signed quotient plus centre, clamped to the screen
    logic [wsr_pkg::CENTRE_W-1:0]         centre;
    logic signed [wsr_pkg::ROW_W-1:0]     q_signed;
    logic signed [wsr_pkg::ROW_W-1:0]     row_raw;
    logic signed [wsr_pkg::ROW_W-1:0]     row_top;
    logic [wsr_pkg::HEIGHT_W-1:0]         row;
    logic [wsr_pkg::WIDTH_W-1:0]          width_eff;
    logic                                 last;
    logic                                 first;

    always_comb begin
        centre   = r_h[wsr_pkg::HEIGHT_W-1:1];
        q_signed = r_neg ? -{2'b00, r_quot} : {2'b00, r_quot};
        row_raw  = q_signed + {3'b000, centre};
        row_top  = {2'b00, r_h} - wsr_pkg::ROW_W'(1);
        if (row_raw < 0)
            row = '0;
        else if (row_raw > row_top)
            row = row_top[wsr_pkg::HEIGHT_W-1:0];
        else
            row = row_raw[wsr_pkg::HEIGHT_W-1:0];

        // zero width behaves as one column; a shrunk width ends the frame early
        width_eff = (r_width == '0) ? wsr_pkg::WIDTH_W'(1) : r_width;
        last      = r_col >= (width_eff - 1'b1);
        first     = (r_col == '0);
    end

    logic finish;
    assign finish = (r_state == wsr_pkg::S_FINISH) && out_free;

    // output register and column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_col       <= '0;
            r_prev      <= '0;
        end else begin
            if (finish) begin
                o_out_valid <= 1'b1;
                r_col       <= last ? '0 : r_col + 1'b1;
                r_prev      <= row;
            end else if (out_beat) begin
                o_out_valid <= 1'b0;
            end
        end
        if (finish) begin
            o_frame_first   <= first;
            o_point_column  <= r_col;
            o_centre_row    <= centre;
            o_span_valid    <= ~first;
            o_span_column   <= first ? '0 : r_col - 1'b1;
            o_span_low_row  <= first ? '0 : ((r_prev < row) ? r_prev : row);
            o_span_high_row <= first ? '0 : ((r_prev < row) ? row : r_prev);
            o_frame_last    <= last;
        end
    end

    // checks on the sequencing and on the span fields
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("sample accepted while the previous one is still in work");

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == wsr_pkg::S_RATIO_WAIT || r_state == wsr_pkg::S_QUOT_WAIT))
        else $error("divider finished outside a wait state");

    a_span_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_valid == !o_frame_first))
        else $error("span flag disagrees with first column");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_low_row <= o_span_high_row))
        else $error("span rows out of order");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out_valid && (r_state == wsr_pkg::S_IDLE))
        else $error("finished column not presented");

endmodule
`default_nettype wire
